[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the tokenizer RTL. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define SEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never comes true outside reset.
`define SEXP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `SEXP_ASSERT(lbl, clk, rst_n, !(expr), msg)

`else

`define SEXP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SEXP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[hw/rtl/sexp_pkg.sv]
// ----------------------------------------------------------------------------
// sexp_pkg
// Types, character codes and helpers shared by the s-expression tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sexp_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 16;
    localparam int OFFSET_BITS = 24;
    localparam int KIND_BITS   = 3;

    // line, column, start and length fill whole bytes at these widths
    localparam int TDATA_BITS = LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS;

    // token queue geometry
    localparam int TOKQ_DEPTH    = 4;
    localparam int TOKQ_PTR_BITS = $clog2(TOKQ_DEPTH);
    localparam int TOKQ_CNT_BITS = $clog2(TOKQ_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ASCII_MAX = 8'd127;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_SIGN = 3'd1,
        MODE_INT  = 3'd2,
        MODE_SYM  = 3'd3,
        MODE_ERR  = 3'd4
    } scan_mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LPAREN = 3'd0,
        KIND_RPAREN = 3'd1,
        KIND_INT    = 3'd2,
        KIND_SYM    = 3'd3,
        KIND_EOF    = 3'd4,
        KIND_ERR    = 3'd5
    } token_kind_t;

    typedef struct packed {
        scan_mode_t             mode;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
        logic [OFFSET_BITS-1:0] offset;
        logic [LINE_BITS-1:0]   pend_line;
        logic [COLUMN_BITS-1:0] pend_column;
        logic [OFFSET_BITS-1:0] pend_start;
        logic [OFFSET_BITS-1:0] pend_length;
    } scan_state_t;

    typedef struct packed {
        token_kind_t            kind;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] length;
        logic                   last_of_run;
    } token_t;

    // up to two tokens written to the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } tok_push_t;

    localparam scan_state_t SCAN_RESET = '{
        mode:        MODE_IDLE,
        line:        '0,
        column:      '0,
        offset:      '0,
        pend_line:   '0,
        pend_column: '0,
        pend_start:  '0,
        pend_length: '0
    };

    function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
        return (&v) ? v : v + LINE_BITS'(1);
    endfunction

    function automatic logic [COLUMN_BITS-1:0] sat_column(input logic [COLUMN_BITS-1:0] v);
        return (&v) ? v : v + COLUMN_BITS'(1);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_offset(input logic [OFFSET_BITS-1:0] v);
        return (&v) ? v : v + OFFSET_BITS'(1);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sexp_scan.sv]
// ----------------------------------------------------------------------------
// sexp_scan
// Per-byte scanner: classifies one byte against the scan state and yields
// the next state and the zero to two tokens that the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module sexp_scan (
    input  sexp_pkg::scan_state_t cur,
    input  logic [7:0]            src_byte,
    input  logic                  end_flag,
    output sexp_pkg::scan_state_t nxt,
    output sexp_pkg::tok_push_t   push
);
    import sexp_pkg::*;

    logic        is_space, is_digit, is_sign, is_lp, is_rp, is_sym;
    logic        was_open, grow, close_tok, taken;
    logic        imm_paren, imm_err, trail, open_new, fin;
    scan_mode_t  grow_mode, new_mode, mode1;
    token_kind_t close_kind;
    scan_state_t upd;
    token_t      t_close, t_imm, t_fin;

    // classify the byte
    always_comb begin
        is_space = (src_byte == CH_SPACE) || (src_byte inside {[CH_TAB:CH_CR]});
        is_digit = src_byte inside {[CH_ZERO:CH_NINE]};
        is_sign  = (src_byte == CH_PLUS) || (src_byte == CH_MINUS);
        is_lp    = (src_byte == CH_LPAREN);
        is_rp    = (src_byte == CH_RPAREN);
        is_sym   = (src_byte <= CH_ASCII_MAX) && !is_space && !is_lp && !is_rp
                   && (src_byte != CH_QUOTE);
    end

    // extend or close the open token
    always_comb begin
        grow      = 1'b0;
        grow_mode = cur.mode;
        was_open  = 1'b0;
        case (cur.mode)
            MODE_SIGN: begin
                was_open = 1'b1;
                if (is_digit) begin
                    grow_mode = MODE_INT;
                    grow      = 1'b1;
                end else if (is_sym) begin
                    grow_mode = MODE_SYM;
                    grow      = 1'b1;
                end
            end
            MODE_INT: begin
                was_open = 1'b1;
                grow     = is_digit;
            end
            MODE_SYM: begin
                was_open = 1'b1;
                grow     = is_sym;
            end
            default: begin
                grow = 1'b0;
            end
        endcase
        close_tok  = was_open && !grow;
        close_kind = (cur.mode == MODE_INT) ? KIND_INT : KIND_SYM;
        taken      = grow;
    end

    // handle a byte between tokens
    always_comb begin
        trail     = !taken && is_space;
        imm_paren = !taken && (is_lp || is_rp);
        open_new  = !taken && (is_digit || is_sym);
        imm_err   = !taken && !is_space && !is_lp && !is_rp && !is_digit && !is_sym;
        if (is_digit) begin
            new_mode = MODE_INT;
        end else if (is_sign) begin
            new_mode = MODE_SIGN;
        end else begin
            new_mode = MODE_SYM;
        end
        if (grow) begin
            mode1 = grow_mode;
        end else if (open_new) begin
            mode1 = new_mode;
        end else if (imm_err) begin
            mode1 = MODE_ERR;
        end else begin
            mode1 = MODE_IDLE;
        end
    end

    // build the state after this byte
    always_comb begin
        upd      = cur;
        upd.mode = mode1;
        if (open_new) begin
            upd.pend_line   = cur.line;
            upd.pend_column = cur.column;
            upd.pend_start  = cur.offset;
            upd.pend_length = OFFSET_BITS'(1);
        end else if (grow) begin
            upd.pend_length = sat_offset(cur.pend_length);
        end
        if (src_byte == CH_LF) begin
            upd.column = '0;
            upd.line   = sat_line(cur.line);
        end else begin
            upd.column = sat_column(cur.column);
        end
        upd.offset = sat_offset(cur.offset);
        fin = end_flag && ((mode1 == MODE_SIGN) || (mode1 == MODE_INT) ||
                           (mode1 == MODE_SYM) || trail);
    end

    // next state
    always_comb begin
        if (end_flag) begin
            nxt = SCAN_RESET;
        end else if (cur.mode == MODE_ERR) begin
            nxt = cur;
        end else begin
            nxt = upd;
        end
    end

    // token outputs
    always_comb begin
        t_close = '{kind: close_kind, line: cur.pend_line, column: cur.pend_column,
                    start: cur.pend_start, length: cur.pend_length, last_of_run: 1'b0};

        t_imm = '{kind: KIND_ERR, line: cur.line, column: cur.column,
                  start: cur.offset, length: '0, last_of_run: 1'b0};
        if (imm_paren) begin
            t_imm.kind   = is_lp ? KIND_LPAREN : KIND_RPAREN;
            t_imm.column = sat_column(cur.column);
            t_imm.length = OFFSET_BITS'(1);
        end

        if (trail) begin
            t_fin = '{kind: KIND_EOF, line: upd.line, column: upd.column,
                      start: upd.offset, length: '0, last_of_run: 1'b0};
        end else begin
            t_fin = '{kind: (mode1 == MODE_INT) ? KIND_INT : KIND_SYM,
                      line: upd.pend_line, column: upd.pend_column,
                      start: upd.pend_start, length: upd.pend_length,
                      last_of_run: 1'b0};
        end

        // compact into slots: close, then immediate, then final
        push.count = 2'd0;
        push.tok0  = t_fin;
        push.tok1  = t_fin;
        if (cur.mode != MODE_ERR) begin
            push.count = 2'({1'b0, close_tok}) + 2'({1'b0, imm_paren || imm_err})
                         + 2'({1'b0, fin});
            if (close_tok) begin
                push.tok0 = t_close;
                push.tok1 = (imm_paren || imm_err) ? t_imm : t_fin;
            end else if (imm_paren || imm_err) begin
                push.tok0 = t_imm;
            end
        end
        push.tok0.last_of_run = (push.count == 2'd1);
        push.tok1.last_of_run = 1'b1;
    end

endmodule

`default_nettype wire

[hw/rtl/sexp_tokq.sv]
// ----------------------------------------------------------------------------
// sexp_tokq
// Token queue: takes up to two tokens a cycle from the scanner and hands
// them to the result channel one per cycle while the channel is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sexp_tokq (
    input  logic                aclk,
    input  logic                aresetn,
    input  sexp_pkg::tok_push_t push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output sexp_pkg::token_t    out_tok
);
    import sexp_pkg::*;

    token_t                   slot_reg [TOKQ_DEPTH];
    logic [TOKQ_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [TOKQ_CNT_BITS-1:0] count_reg, count_next;
    logic [TOKQ_PTR_BITS-1:0] wr_ptr_plus1;
    logic                     pop;

    // room for a worst-case pair of tokens
    assign room      = (count_reg <= TOKQ_CNT_BITS'(TOKQ_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_tok   = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // advance pointers and fill count
    always_comb begin
        wr_ptr_plus1 = wr_ptr_reg + TOKQ_PTR_BITS'(1);
        wr_ptr_next  = wr_ptr_reg + TOKQ_PTR_BITS'(push.count);
        rd_ptr_next  = rd_ptr_reg + TOKQ_PTR_BITS'(pop);
        count_next   = count_reg + TOKQ_CNT_BITS'(push.count) - TOKQ_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // write incoming tokens
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2) begin
            slot_reg[wr_ptr_plus1] <= push.tok1;
        end
    end

    `SEXP_ASSERT(a_cnt_bound, aclk, aresetn, count_reg <= TOKQ_CNT_BITS'(TOKQ_DEPTH), "token queue over depth")
    `SEXP_ASSERT(a_ptr_match, aclk, aresetn, (count_reg == TOKQ_CNT_BITS'(TOKQ_DEPTH)) || (TOKQ_PTR_BITS'(wr_ptr_reg - rd_ptr_reg) == count_reg[TOKQ_PTR_BITS-1:0]), "queue pointers disagree with count")
    `SEXP_ASSERT_NEVER(a_push_full, aclk, aresetn, (push.count != 2'd0) && !room, "push into queue without room")

endmodule

`default_nettype wire

[hw/rtl/sexpr_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// sexpr_tokenizer_core
// S-expression tokenizer: source bytes in, tokens with position out.
// ----------------------------------------------------------------------------
// Accepts one source byte per cycle while the queue has room and emits
// parenthesis, integer, symbol, eof and error tokens with line, column, start
// offset and length. A byte is held in an input register, scanned by
// combinational logic against the scan state, and its zero to two tokens are
// written into a four-entry token queue that feeds the result channel one
// token per cycle while the sink is ready. Sustained rate is one byte per
// cycle as long as the sink takes tokens as fast as they are made; the queue
// drains at most one token per cycle, so a byte that yields two tokens
// adds to the queue backlog. The stream restarts at line 0, column 0,
// offset 0 after every byte marked tlast.
`default_nettype none

`include "assert_macros.svh"

module sexpr_tokenizer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] source_byte
    input  logic                              s_tlast,   // end_of_text
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] token_line, [31:16] token_column, [55:32] token_start,
    // [79:56] token_length
    output logic [sexp_pkg::TDATA_BITS-1:0]   m_tdata,
    output logic [sexp_pkg::KIND_BITS-1:0]    m_tuser,   // [2:0] token_kind
    output logic                              m_tlast    // last_of_run
);
    import sexp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    scan_state_t state_reg, state_next, scan_next;
    tok_push_t   scan_push, q_push;
    token_t      q_tok;
    logic        q_room, fire, s_acc;

    // scan the held byte when the queue can take its tokens
    assign fire     = in_valid_reg && q_room;
    assign s_tready = !in_valid_reg || fire;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = s_acc ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        state_next    = fire ? scan_next : state_reg;
        q_push        = scan_push;
        if (!fire) begin
            q_push.count = 2'd0;
        end
    end

    // hold the input request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= SCAN_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    sexp_scan u_scan (
        .cur      (state_reg),
        .src_byte (in_byte_reg),
        .end_flag (in_last_reg),
        .nxt      (scan_next),
        .push     (scan_push)
    );

    sexp_tokq u_tokq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .room      (q_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (q_tok)
    );

    // pack the result request
    assign m_tdata = {q_tok.length, q_tok.start, q_tok.column, q_tok.line};
    assign m_tuser = q_tok.kind;
    assign m_tlast = q_tok.last_of_run;

    `SEXP_ASSERT(a_err_quiet, aclk, aresetn, (fire && (state_reg.mode == MODE_ERR)) |-> (scan_push.count == 2'd0), "tokens emitted in error mode")
    `SEXP_ASSERT(a_err_hold, aclk, aresetn, (fire && (state_reg.mode == MODE_ERR) && !in_last_reg) |=> (state_reg.mode == MODE_ERR), "error mode left before stream end")
    `SEXP_ASSERT(a_end_reset, aclk, aresetn, (fire && in_last_reg) |=> ((state_reg.mode == MODE_IDLE) && (state_reg.offset == '0)), "scan state not cleared at stream end")

endmodule

`default_nettype wire
